FILE: rtl/ukl_pkg.sv
// ============================================================================
// ukl_pkg: shared types and constants of the keyed list engine
// Field widths, operation and status codes, sequencer states, cell commands.
// ============================================================================
package ukl_pkg;

    // Widths of the fields on the channels
    localparam int KIND_W     = 3;
    localparam int KEY_FLD_W  = 16;
    localparam int TAG_FLD_W  = 16;
    localparam int STATUS_W   = 2;
    localparam int COUNT_FLD_W = 7;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RM_FIRST  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RM_LAST   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RM_KEY    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FIND_KEY  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_REPL_KEY  = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_SPAN,
        ST_GATHER,
        ST_DONE
    } state_t;

    // Update command broadcast to every cell
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SHR,      // every cell takes its left neighbor
        CMD_SHL,      // cells at or above the hit take their right neighbor
        CMD_PUT_SEL,  // the selected cell takes the new entry
        CMD_PUT_CNT   // the cell just past the last entry takes the new entry
    } cmd_t;

    // Control broadcast to the cells
    typedef struct packed {
        cmd_t              cmd;
        logic [KIND_W-1:0] kind;
    } ukl_ctl_t;

endpackage

FILE: rtl/ukl_if.sv
// ============================================================================
// ukl_if: request and response channels of the keyed list engine
// Valid/ready handshake; a word moves when valid and ready are both high.
// ============================================================================
interface ukl_req_if;
    import ukl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [KEY_FLD_W-1:0] search_key;
    logic [KEY_FLD_W-1:0] new_key;
    logic [TAG_FLD_W-1:0] new_tag;

    modport source (output valid, output kind, output search_key, output new_key,
                    output new_tag, input ready);
    modport sink   (input valid, input kind, input search_key, input new_key,
                    input new_tag, output ready);
endinterface

interface ukl_rsp_if;
    import ukl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [KEY_FLD_W-1:0]   entry_key;
    logic [TAG_FLD_W-1:0]   entry_tag;
    logic [COUNT_FLD_W-1:0] entry_count;

    modport source (output valid, output status, output entry_key, output entry_tag,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input entry_key, input entry_tag,
                    input entry_count, output ready);
endinterface

FILE: rtl/ukl_cell.sv
// ============================================================================
// ukl_cell: one position of the list
// Holds one entry, flags a hit for the current operation and shifts to or
// from its neighbors on the broadcast command.
// ============================================================================
module ukl_cell #(
    parameter int INDEX      = 0,
    parameter int LIST_DEPTH = 64,
    parameter int KEY_BITS   = 16,
    parameter int TAG_BITS   = 16,
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1),
    localparam int ENT_W     = KEY_BITS + TAG_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ukl_pkg::ukl_ctl_t    ctl,
    input  logic [CNT_W-1:0]     count,
    input  logic [KEY_BITS-1:0]  skey,
    input  logic [ENT_W-1:0]     nent,
    input  logic [ENT_W-1:0]     left_ent,
    input  logic [ENT_W-1:0]     right_ent,
    input  logic                 sel,
    input  logic                 tail,
    output logic [ENT_W-1:0]     ent,
    output logic                 hit
);
    import ukl_pkg::*;

    logic [ENT_W-1:0] ent_reg;
    logic [ENT_W-1:0] ent_next;
    logic             hit_reg;
    logic             hit_next;
    logic             occ;

    // Position holds a live entry
    assign occ = CNT_W'(INDEX) < count;

    // Hit for the operation in flight
    always_comb
    begin
        case (ctl.kind)
            KIND_RM_FIRST:
                hit_next = occ && (INDEX == 0);
            KIND_RM_LAST:
                hit_next = (count == CNT_W'(INDEX + 1));
            KIND_RM_KEY, KIND_FIND_KEY, KIND_REPL_KEY:
                hit_next = occ && (ent_reg[ENT_W-1 -: KEY_BITS] == skey);
            default:
                hit_next = 1'b0;
        endcase
    end

    // Entry update
    always_comb
    begin
        ent_next = ent_reg;
        case (ctl.cmd)
            CMD_SHR:
                ent_next = left_ent;
            CMD_SHL:
                if (tail)
                begin
                    ent_next = right_ent;
                end
            CMD_PUT_SEL:
                if (sel)
                begin
                    ent_next = nent;
                end
            CMD_PUT_CNT:
                if (count == CNT_W'(INDEX))
                begin
                    ent_next = nent;
                end
            default:
                ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign ent = ent_reg;
    assign hit = hit_reg;

endmodule

FILE: rtl/ukl_gather.sv
// ============================================================================
// ukl_gather: read-out of the selected cell
// Two-level OR tree over the one-hot select; groups of eight are registered,
// the group results are merged combinationally.
// ============================================================================
module ukl_gather #(
    parameter int LIST_DEPTH = 64,
    parameter int KEY_BITS   = 16,
    parameter int TAG_BITS   = 16,
    localparam int ENT_W     = KEY_BITS + TAG_BITS
) (
    input  logic                             clk,
    input  logic [LIST_DEPTH-1:0]            sel,
    input  logic [LIST_DEPTH-1:0][ENT_W-1:0] ent,
    output logic [ENT_W-1:0]                 ent_out
);
    localparam int GROUP  = 8;
    localparam int GROUPS = (LIST_DEPTH + GROUP - 1) / GROUP;

    logic [GROUPS-1:0][ENT_W-1:0] grp_reg;
    logic [GROUPS-1:0][ENT_W-1:0] grp_next;

    // First level: masked OR inside each group
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < LIST_DEPTH)
                begin
                    if (sel[g * GROUP + j])
                    begin
                        grp_next[g] = grp_next[g] | ent[g * GROUP + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    // Second level: merge the groups
    always_comb
    begin
        ent_out = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            ent_out = ent_out | grp_reg[g];
        end
    end

endmodule

FILE: rtl/unordered_keyed_list_engine.sv
// ============================================================================
// unordered_keyed_list_engine: bounded position-ordered list of keyed entries
// Insert front/back, remove first/last/by key, find and replace by key over a
// row of cells, one operation at a time.
// ============================================================================
//
//   channel   dir   handshake       word
//   -------   ---   -------------   -------------------------------------------
//   req       in    valid / ready   kind, search_key, new_key, new_tag
//   rsp       out   valid / ready   status, entry_key, entry_tag, entry_count
//
// An operation runs these steps from acceptance to a loaded response: match
// in every cell, first-hit pick (a LIST_DEPTH-bit add), span mask and first
// tree level, second tree level with the cell update, response load.
// req.ready is high only while the sequencer is idle, so a new request is taken
// only after the previous operation has loaded its response.
// A response that is not taken holds the sequencer in its last step; the next
// request is taken once that response register has been loaded.
// Reset clears the count and control; cell contents are undefined until
// written and are never read past the count.
//
module unordered_keyed_list_engine #(
    parameter int LIST_DEPTH = 64,
    parameter int KEY_BITS   = 16,
    parameter int TAG_BITS   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ukl_req_if.sink   req,
    ukl_rsp_if.source rsp
);
    import ukl_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int ENT_W = KEY_BITS + TAG_BITS;

    state_t state_reg;
    state_t state_next;

    // Operation word
    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_BITS-1:0] skey_reg;
    logic [KEY_BITS-1:0] nkey_reg;
    logic [TAG_BITS-1:0] ntag_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [LIST_DEPTH-1:0] hit_vec;
    logic [LIST_DEPTH-1:0] sel_reg;
    logic [LIST_DEPTH-1:0] tail_reg;
    logic                  found_reg;

    // Result held between the update and the response load
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic [ENT_W-1:0]    res_ent_reg;

    // Response register
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [KEY_FLD_W-1:0]   out_key_reg;
    logic [TAG_FLD_W-1:0]   out_tag_reg;
    logic [COUNT_FLD_W-1:0] out_count_reg;

    logic     in_fire;
    logic     out_load;
    ukl_ctl_t ctl;
    cmd_t     cmd;

    logic [LIST_DEPTH-1:0][ENT_W-1:0] ent_chain;
    logic [ENT_W-1:0]                 nent;
    logic [ENT_W-1:0]                 gather_ent;

    assign req.ready = (state_reg == ST_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign nent      = {nkey_reg, ntag_reg};
    assign ctl.cmd   = cmd;
    assign ctl.kind  = kind_reg;

    // Row of cells
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [ENT_W-1:0] left_ent;
        logic [ENT_W-1:0] right_ent;

        if (i == 0)
        begin : g_head
            assign left_ent = nent;
        end
        else
        begin : g_body
            assign left_ent = ent_chain[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right_ent = ent_chain[i];
        end
        else
        begin : g_inner
            assign right_ent = ent_chain[i+1];
        end

        ukl_cell #(
            .INDEX      (i),
            .LIST_DEPTH (LIST_DEPTH),
            .KEY_BITS   (KEY_BITS),
            .TAG_BITS   (TAG_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .count     (count_reg),
            .skey      (skey_reg),
            .nent      (nent),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .sel       (sel_reg[i]),
            .tail      (tail_reg[i]),
            .ent       (ent_chain[i]),
            .hit       (hit_vec[i])
        );
    end

    // Read-out tree
    ukl_gather #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_BITS   (KEY_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_gather (
        .clk     (clk),
        .sel     (sel_reg),
        .ent     (ent_chain),
        .ent_out (gather_ent)
    );

    // Sequencer: next state, status, cell command, count
    always_comb
    begin
        state_next      = state_reg;
        cmd             = CMD_NONE;
        res_status_next = STAT_OK;
        count_next      = count_reg;
        out_load        = 1'b0;

        // Status of the operation in flight
        if (kind_reg == KIND_INS_FRONT || kind_reg == KIND_INS_BACK)
        begin
            if (count_reg == CNT_W'(LIST_DEPTH))
            begin
                res_status_next = STAT_FULL;
            end
        end
        else if (kind_reg inside {KIND_RM_FIRST, KIND_RM_LAST, KIND_RM_KEY,
                                  KIND_FIND_KEY, KIND_REPL_KEY})
        begin
            if (count_reg == '0)
            begin
                res_status_next = STAT_EMPTY;
            end
            else if (!found_reg)
            begin
                res_status_next = STAT_NOT_FOUND;
            end
        end

        case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    state_next = ST_MATCH;
                end
            ST_MATCH:
                state_next = ST_PICK;
            ST_PICK:
                state_next = ST_SPAN;
            ST_SPAN:
                state_next = ST_GATHER;
            ST_GATHER:
            begin
                state_next = ST_DONE;
                if (res_status_next == STAT_OK)
                begin
                    case (kind_reg)
                        KIND_INS_FRONT:
                        begin
                            cmd        = CMD_SHR;
                            count_next = count_reg + CNT_W'(1);
                        end
                        KIND_INS_BACK:
                        begin
                            cmd        = CMD_PUT_CNT;
                            count_next = count_reg + CNT_W'(1);
                        end
                        KIND_RM_FIRST, KIND_RM_LAST, KIND_RM_KEY:
                        begin
                            cmd        = CMD_SHL;
                            count_next = count_reg - CNT_W'(1);
                        end
                        KIND_REPL_KEY:
                            cmd = CMD_PUT_SEL;
                        default:
                            cmd = CMD_NONE;
                    endcase
                end
            end
            ST_DONE:
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Operation word capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= req.kind;
            skey_reg <= KEY_BITS'(req.search_key);
            nkey_reg <= KEY_BITS'(req.new_key);
            ntag_reg <= TAG_BITS'(req.new_tag);
        end
    end

    // First hit and the span at and above it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            tail_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_PICK)
            begin
                sel_reg   <= hit_vec & (~hit_vec + LIST_DEPTH'(1));
                found_reg <= |hit_vec;
            end
            if (state_reg == ST_SPAN)
            begin
                tail_reg <= ~(sel_reg - LIST_DEPTH'(1));
            end
        end
    end

    // Result capture at the update
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GATHER)
        begin
            res_status_reg <= res_status_next;
            res_ent_reg    <= gather_ent;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= KEY_FLD_W'(res_ent_reg[ENT_W-1 -: KEY_BITS]);
            out_tag_reg    <= TAG_FLD_W'(res_ent_reg[TAG_BITS-1:0]);
            out_count_reg  <= COUNT_FLD_W'(count_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_key   = out_key_reg;
    assign rsp.entry_tag   = out_tag_reg;
    assign rsp.entry_count = out_count_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPAN) |-> $onehot0(sel_reg))
        else $error("more than one cell selected");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPAN && found_reg) |-> $onehot(sel_reg))
        else $error("hit reported but no cell selected");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GATHER) |-> ((sel_reg & ~tail_reg) == '0))
        else $error("selected cell outside the shift span");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_GATHER) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed outside the update step");

endmodule
